>>> rtl/core/escu_pkg.sv
// Shared constants and types for the environmental sensor compensation unit.
`default_nettype none

package escu_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP       = 3'd0,
		CFG_PRESS_LOW  = 3'd1,
		CFG_PRESS_HIGH = 3'd2,
		CFG_PRESS_LAST = 3'd3,
		CFG_HUM        = 3'd4
	} cfg_idx_t;

	// Stage numbers of the main pipeline.
	localparam int STG_TEMP = 4;
	localparam int STG_HUM = 14;
	localparam int STG_PREP = 12;
	localparam int DIV_BITS = 2;
	localparam int DIV_W = 64;
	localparam int STG_DIV_LAST = STG_PREP + DIV_W / DIV_BITS;
	localparam int STG_OUT = STG_DIV_LAST + 7;

	localparam logic signed [32:0] PRESS_T_OFS = 33'sd128000;
	localparam logic signed [31:0] HUM_T_OFS = 32'sd76800;
	localparam logic signed [31:0] TEMP_RND = 32'sd128;
	localparam logic [31:0] HUM_A_RND = 32'd16384;
	localparam logic signed [31:0] HUM_C_OFS = 32'sd32768;
	localparam logic signed [31:0] HUM_D_OFS = 32'sd2097152;
	localparam logic signed [31:0] HUM_E_RND = 32'sd8192;
	localparam logic signed [31:0] HUM_MAX = 32'sd419430400;
	localparam logic [63:0] PRESS_G_OFS = 64'h0000_8000_0000_0000;
	localparam logic [20:0] PRESS_FULL = 21'h100000;
	localparam logic [11:0] PRESS_SCALE = 12'd3125;

	typedef struct packed {
		logic [30:0] rem;
		logic [63:0] quo;
	} div_t;

endpackage

`default_nettype wire

>>> rtl/core/env_sensor_compensation_unit.sv
// Top level of the environmental sensor compensation unit: a fully pipelined datapath.
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    raw_temperature, raw_pressure, raw_humidity
// out      out  out_valid / out_stall  temperature, pressure, humidity, pressure_invalid
// cfg      in   cfg_write              cfg_index, cfg_data
//
// One sample enters per cycle unless a stalled result holds the pipeline.
// The pipeline depth is set by the 64-bit signed divider, which resolves two quotient bits in
// each of its 32 stages, plus the multiply stages around it.
// Reset clears the valid bits and the calibration registers.
// A stalled result holds the whole pipeline, and the input is stalled in the same cycle.

module env_sensor_compensation_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [19:0]                   raw_temperature,
	input  wire logic [19:0]                   raw_pressure,
	input  wire logic [15:0]                   raw_humidity,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [31:0]                 temperature,
	output logic [31:0]                        pressure,
	output logic [16:0]                        humidity,
	output logic                               pressure_invalid,
	input  wire logic                          cfg_write,
	input  wire logic [escu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [escu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import escu_pkg::*;

	logic [47:0] temp_calib_q;
	logic [63:0] press_calib_low_q;
	logic [63:0] press_calib_high_q;
	logic [15:0] press_calib_last_q;
	logic [63:0] hum_calib_q;

	logic [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic signed [11:0] h4, h5;
	logic signed [7:0] h6;
	logic [7:0] h1, h3;

	logic [STG_OUT:1] vld_s;
	logic adv;

	// Delay lines and pipeline registers.
	logic [19:0] rawp_s [1:8];
	logic [15:0] rawh_s [1:5];
	logic signed [31:0] temp_s [STG_TEMP:STG_OUT];
	logic [16:0] hum_s [STG_HUM:STG_OUT];
	logic inv_s [STG_PREP:STG_OUT];
	logic signed [31:0] ha_s [6:10];
	logic signed [31:0] hv_s [11:13];
	logic signed [48:0] pw5_s [5:6];
	logic signed [48:0] pw2_s [5:7];
	logic [63:0] dq_s [STG_PREP:STG_DIV_LAST];
	logic [30:0] dr_s [STG_PREP:STG_DIV_LAST];
	logic [30:0] dv_s [STG_PREP:STG_DIV_LAST];
	logic sgn_s [STG_PREP:STG_DIV_LAST];
	logic [63:0] pq_s [STG_DIV_LAST+1:STG_DIV_LAST+3];
	div_t div_nx [STG_PREP+1:STG_DIV_LAST];

	logic signed [31:0] ta_s1, tx_s1, var1_s2, tm_s2, tfine_s3;
	logic signed [32:0] pw_s4;
	logic signed [31:0] hum_v_s4;
	logic signed [31:0] h5v_s5, h6v_s5, h3v_s5;
	logic [63:0] psq_s5;
	logic signed [31:0] hb_s6, hc_s6;
	logic signed [48:0] alo_s6, dlo_s6;
	logic [31:0] ahi_s6, dhi_s6;
	logic signed [31:0] hbc_s7;
	logic [63:0] aa_s7, bc_s7, dd_s7;
	logic signed [31:0] hd_s8;
	logic [63:0] w2_s8, w1x_s8;
	logic signed [31:0] hdh2_s9;
	logic [63:0] g_s9, m_s9;
	logic signed [31:0] he_s10;
	logic [47:0] flo_s10;
	logic [31:0] fhi_s10;
	logic [43:0] nlo_s10;
	logic [31:0] nhi_s10;
	logic [30:0] den_s11;
	logic [63:0] num_s11;
	logic signed [31:0] hss_s12;
	logic signed [31:0] h1m_s13;
	logic signed [48:0] xlo_s46, ylo_s46;
	logic [31:0] xhi_s46, yhi_s46;
	logic [63:0] xx_s47, w2p_s47;
	logic [63:0] yll_s48;
	logic [31:0] ylh_s48, yhl_s48;
	logic [63:0] pws_s48, pws_s49, ysum_s49, tot_s50;
	logic [31:0] press_s51;

	// Combinational terms of each stage.
	logic signed [17:0] t_dif;
	logic signed [33:0] t_pa;
	logic signed [16:0] t_x;
	logic signed [33:0] t_xx;
	logic signed [31:0] t_xs;
	logic signed [47:0] t_m;
	logic signed [31:0] t_r5;
	logic signed [43:0] h_5v;
	logic signed [39:0] h_6v;
	logic signed [40:0] h_3v;
	logic signed [65:0] p_sq;
	logic signed [48:0] p_w5, p_w2;
	logic [31:0] ha_pre;
	logic signed [48:0] a_lo, d_lo;
	logic signed [47:0] a_hi, d_hi;
	logic signed [63:0] h_bc;
	logic signed [63:0] alo_x, dlo_x, pw5_x, p4_x;
	logic signed [63:0] dd_sh, pw2_x;
	logic signed [47:0] h_d2;
	logic [20:0] p_pos;
	logic signed [31:0] h_e;
	logic [47:0] f_lo, f_hi;
	logic [43:0] n_lo, n_hi;
	logic signed [63:0] h_v;
	logic [63:0] f_sum;
	logic signed [31:0] h_s;
	logic signed [63:0] h_ss;
	logic signed [40:0] h_1m;
	logic signed [31:0] h_f;
	logic [31:0] h_c;
	logic signed [63:0] x_ps;
	logic signed [48:0] x_lo, y_lo;
	logic signed [47:0] x_hi, y_hi;
	logic signed [63:0] xlo_x, ylo_x;
	logic signed [63:0] ps2;
	logic [63:0] y_ll, y_lh, y_hl;
	logic signed [63:0] w2p_sh, y_sh;

	function automatic div_t div_step(input logic [30:0] rem, input logic [63:0] quo,
		input logic [30:0] dvs);
		logic [31:0] t;
		div_t r;
		r.rem = rem;
		r.quo = quo;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.quo[63]};
			r.quo = {r.quo[62:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				r.quo[0] = 1'b1;
			end
			r.rem = t[30:0];
		end
		return r;
	endfunction

	assign t1 = temp_calib_q[15:0];
	assign t2 = temp_calib_q[31:16];
	assign t3 = temp_calib_q[47:32];
	assign p1 = press_calib_low_q[15:0];
	assign p2 = press_calib_low_q[31:16];
	assign p3 = press_calib_low_q[47:32];
	assign p4 = press_calib_low_q[63:48];
	assign p5 = press_calib_high_q[15:0];
	assign p6 = press_calib_high_q[31:16];
	assign p7 = press_calib_high_q[47:32];
	assign p8 = press_calib_high_q[63:48];
	assign p9 = press_calib_last_q;
	assign h1 = hum_calib_q[7:0];
	assign h2 = hum_calib_q[23:8];
	assign h3 = hum_calib_q[31:24];
	assign h4 = hum_calib_q[43:32];
	assign h5 = hum_calib_q[55:44];
	assign h6 = hum_calib_q[63:56];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_calib_low_q <= '0;
			press_calib_high_q <= '0;
			press_calib_last_q <= '0;
			hum_calib_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TEMP:       temp_calib_q <= cfg_data[47:0];
				CFG_PRESS_LOW:  press_calib_low_q <= cfg_data;
				CFG_PRESS_HIGH: press_calib_high_q <= cfg_data;
				CFG_PRESS_LAST: press_calib_last_q <= cfg_data[15:0];
				CFG_HUM:        hum_calib_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !(vld_s[STG_OUT] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STG_OUT-1:1], in_valid};
		end
	end

	always_comb begin
		// Temperature.
		t_dif = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		t_pa = t_dif * t2;
		t_x = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
		t_xx = t_x * t_x;
		t_xs = tx_s1 >>> 12;
		t_m = t_xs * t3;
		t_r5 = tfine_s3 + (tfine_s3 <<< 2) + TEMP_RND;

		// Humidity.
		h_5v = h5 * hum_v_s4;
		h_6v = hum_v_s4 * h6;
		h_3v = hum_v_s4 * $signed({1'b0, h3});
		ha_pre = {2'b00, rawh_s[5], 14'b0} - {h4, 20'b0} - h5v_s5 + HUM_A_RND;
		h_bc = hb_s6 * hc_s6;
		h_d2 = hd_s8 * h2;
		h_e = hdh2_s9 + HUM_E_RND;
		h_v = ha_s[10] * he_s10;
		h_s = hv_s[11] >>> 15;
		h_ss = h_s * h_s;
		h_1m = (hss_s12 >>> 7) * $signed({1'b0, h1});
		h_f = hv_s[13] - (h1m_s13 >>> 4);
		if (h_f < 0) begin
			h_c = '0;
		end else if (h_f > HUM_MAX) begin
			h_c = HUM_MAX;
		end else begin
			h_c = h_f;
		end

		// Pressure, ahead of the divider.
		p_sq = pw_s4 * pw_s4;
		p_w5 = pw_s4 * p5;
		p_w2 = pw_s4 * p2;
		a_lo = $signed({1'b0, psq_s5[31:0]}) * p6;
		a_hi = $signed(psq_s5[63:32]) * p6;
		d_lo = $signed({1'b0, psq_s5[31:0]}) * p3;
		d_hi = $signed(psq_s5[63:32]) * p3;
		alo_x = alo_s6;
		dlo_x = dlo_s6;
		pw5_x = pw5_s[6];
		p4_x = p4;
		dd_sh = $signed(dd_s7) >>> 8;
		pw2_x = pw2_s[7];
		p_pos = PRESS_FULL - {1'b0, rawp_s[8]};
		f_lo = g_s9[31:0] * p1;
		f_hi = g_s9[63:32] * p1;
		n_lo = m_s9[31:0] * PRESS_SCALE;
		n_hi = m_s9[63:32] * PRESS_SCALE;
		f_sum = {fhi_s10, 32'b0} + {16'b0, flo_s10};

		// Pressure, after the divider.
		x_ps = $signed(pq_s[STG_DIV_LAST+1]) >>> 13;
		x_lo = $signed({1'b0, x_ps[31:0]}) * p9;
		x_hi = $signed(x_ps[63:32]) * p9;
		y_lo = $signed({1'b0, pq_s[STG_DIV_LAST+1][31:0]}) * p8;
		y_hi = $signed(pq_s[STG_DIV_LAST+1][63:32]) * p8;
		xlo_x = xlo_s46;
		ylo_x = ylo_s46;
		ps2 = $signed(pq_s[STG_DIV_LAST+3]) >>> 13;
		y_ll = xx_s47[31:0] * ps2[31:0];
		y_lh = xx_s47[31:0] * ps2[63:32];
		y_hl = xx_s47[63:32] * ps2[31:0];
		w2p_sh = $signed(w2p_s47) >>> 19;
		y_sh = $signed(ysum_s49) >>> 25;
	end

	always_comb begin
		for (int k = STG_PREP + 1; k <= STG_DIV_LAST; k++) begin
			div_nx[k] = div_step(dr_s[k-1], dq_s[k-1], dv_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rawp_s[1] <= raw_pressure;
			rawh_s[1] <= raw_humidity;
			for (int k = 2; k <= 8; k++) rawp_s[k] <= rawp_s[k-1];
			for (int k = 2; k <= 5; k++) rawh_s[k] <= rawh_s[k-1];

			ta_s1 <= t_pa[31:0];
			tx_s1 <= t_xx[31:0];
			var1_s2 <= ta_s1 >>> 11;
			tm_s2 <= t_m[31:0];
			tfine_s3 <= var1_s2 + (tm_s2 >>> 14);
			temp_s[STG_TEMP] <= t_r5 >>> 8;
			pw_s4 <= {tfine_s3[31], tfine_s3} - PRESS_T_OFS;
			hum_v_s4 <= tfine_s3 - HUM_T_OFS;
			for (int k = STG_TEMP + 1; k <= STG_OUT; k++) temp_s[k] <= temp_s[k-1];

			h5v_s5 <= h_5v[31:0];
			h6v_s5 <= h_6v[31:0];
			h3v_s5 <= h_3v[31:0];
			ha_s[6] <= $signed(ha_pre) >>> 15;
			hb_s6 <= h6v_s5 >>> 10;
			hc_s6 <= (h3v_s5 >>> 11) + HUM_C_OFS;
			for (int k = 7; k <= 10; k++) ha_s[k] <= ha_s[k-1];
			hbc_s7 <= h_bc[31:0];
			hd_s8 <= (hbc_s7 >>> 10) + HUM_D_OFS;
			hdh2_s9 <= h_d2[31:0];
			he_s10 <= h_e >>> 14;
			hv_s[11] <= h_v[31:0];
			hv_s[12] <= hv_s[11];
			hv_s[13] <= hv_s[12];
			hss_s12 <= h_ss[31:0];
			h1m_s13 <= h_1m[31:0];
			hum_s[STG_HUM] <= h_c[28:12];
			for (int k = STG_HUM + 1; k <= STG_OUT; k++) hum_s[k] <= hum_s[k-1];

			psq_s5 <= p_sq[63:0];
			pw5_s[5] <= p_w5;
			pw5_s[6] <= pw5_s[5];
			pw2_s[5] <= p_w2;
			pw2_s[6] <= pw2_s[5];
			pw2_s[7] <= pw2_s[6];
			alo_s6 <= a_lo;
			ahi_s6 <= a_hi[31:0];
			dlo_s6 <= d_lo;
			dhi_s6 <= d_hi[31:0];
			aa_s7 <= {ahi_s6, 32'b0} + alo_x;
			bc_s7 <= (pw5_x <<< 17) + (p4_x <<< 35);
			dd_s7 <= {dhi_s6, 32'b0} + dlo_x;
			w2_s8 <= aa_s7 + bc_s7;
			w1x_s8 <= dd_sh + (pw2_x <<< 12);
			g_s9 <= w1x_s8 + PRESS_G_OFS;
			m_s9 <= {12'b0, p_pos, 31'b0} - w2_s8;
			flo_s10 <= f_lo;
			fhi_s10 <= f_hi[31:0];
			nlo_s10 <= n_lo;
			nhi_s10 <= n_hi[31:0];
			den_s11 <= f_sum[63:33];
			num_s11 <= {nhi_s10, 32'b0} + {20'b0, nlo_s10};

			dq_s[STG_PREP] <= num_s11[63] ? 64'd0 - num_s11 : num_s11;
			dr_s[STG_PREP] <= '0;
			dv_s[STG_PREP] <= den_s11[30] ? 31'd0 - den_s11 : den_s11;
			sgn_s[STG_PREP] <= num_s11[63] ^ den_s11[30];
			inv_s[STG_PREP] <= (den_s11 == '0);
			for (int k = STG_PREP + 1; k <= STG_DIV_LAST; k++) begin
				dq_s[k] <= div_nx[k].quo;
				dr_s[k] <= div_nx[k].rem;
				dv_s[k] <= dv_s[k-1];
				sgn_s[k] <= sgn_s[k-1];
			end
			for (int k = STG_PREP + 1; k <= STG_OUT; k++) inv_s[k] <= inv_s[k-1];

			pq_s[STG_DIV_LAST+1] <= sgn_s[STG_DIV_LAST] ? 64'd0 - dq_s[STG_DIV_LAST] :
				dq_s[STG_DIV_LAST];
			pq_s[STG_DIV_LAST+2] <= pq_s[STG_DIV_LAST+1];
			pq_s[STG_DIV_LAST+3] <= pq_s[STG_DIV_LAST+2];
			xlo_s46 <= x_lo;
			xhi_s46 <= x_hi[31:0];
			ylo_s46 <= y_lo;
			yhi_s46 <= y_hi[31:0];
			xx_s47 <= {xhi_s46, 32'b0} + xlo_x;
			w2p_s47 <= {yhi_s46, 32'b0} + ylo_x;
			yll_s48 <= y_ll;
			ylh_s48 <= y_lh[31:0];
			yhl_s48 <= y_hl[31:0];
			pws_s48 <= pq_s[STG_DIV_LAST+3] + w2p_sh;
			ysum_s49 <= yll_s48 + {ylh_s48 + yhl_s48, 32'b0};
			pws_s49 <= pws_s48;
			tot_s50 <= pws_s49 + y_sh;
			press_s51 <= inv_s[STG_OUT-1] ? '0 :
				tot_s50[39:8] + {{12{p7[15]}}, p7, 4'b0};
		end
	end

	assign out_valid = vld_s[STG_OUT];
	assign temperature = temp_s[STG_OUT];
	assign pressure = press_s51;
	assign humidity = hum_s[STG_OUT];
	assign pressure_invalid = inv_s[STG_OUT];

	// A result flagged invalid carries a zero pressure.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pressure_invalid) |-> (pressure == '0))
		else $error("invalid pressure result is not zero");

	// The humidity clamp keeps every result within its range.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity <= 17'd102400))
		else $error("humidity result out of range");

	// The input only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// A transfer on the input marks the first stage valid.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[1])
		else $error("accepted transfer lost at pipeline entry");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the environmental sensor compensation unit, checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import escu_pkg::*;

	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} sample_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] press;
		logic [16:0] hum;
		logic        inval;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic [15:0] raw_humidity = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [31:0] temperature;
	logic [31:0] pressure;
	logic [16:0] humidity;
	logic pressure_invalid;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [47:0] cal_t;
	logic [63:0] cal_pl, cal_ph, cal_h;
	logic [15:0] cal_p9;

	sample_t pending_samples[$];
	reading_t expected_readings[$];
	int mismatches = 0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_off = 0;
	bit hold_done = 0;
	bit stim_done = 0;
	bit in_acc = 0;
	bit out_acc = 0;

	env_sensor_compensation_unit dut (.*);

	always #6 clk = ~clk;

	function automatic logic [31:0] sx32(logic [63:0] v, int w);
		logic [63:0] r;
		r = v << (64 - w);
		r = $signed(r) >>> (64 - w);
		return r[31:0];
	endfunction

	function automatic logic [63:0] sx64(logic [63:0] v, int w);
		logic [63:0] r;
		r = v << (64 - w);
		return $signed(r) >>> (64 - w);
	endfunction

	function automatic logic [31:0] sr32(logic [31:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sr64(logic [63:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic reading_t compensate(sample_t s);
		reading_t r;
		logic [31:0] t1, t2, t3, a, v1, x, v2, tfine;
		logic [63:0] w1, w2, p, ps, an, ad, q, press;
		logic [63:0] pk[10];
		logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, hb, hc, hd, he, hv, hs;
		t1 = {16'd0, cal_t[15:0]};
		t2 = sx32(cal_t >> 16, 16);
		t3 = sx32(cal_t >> 32, 16);
		a = ({15'd0, s.raw_t[19:3]} - (t1 << 1)) * t2;
		v1 = sr32(a, 11);
		x = {16'd0, s.raw_t[19:4]} - t1;
		v2 = sr32(sr32(x * x, 12) * t3, 14);
		tfine = v1 + v2;
		r.temp = sr32(tfine * 32'd5 + 32'd128, 8);
		pk[1] = {48'd0, cal_pl[15:0]};
		for (int i = 2; i <= 4; i++) pk[i] = sx64(cal_pl >> (16 * (i - 1)), 16);
		for (int i = 5; i <= 8; i++) pk[i] = sx64(cal_ph >> (16 * (i - 5)), 16);
		pk[9] = sx64({48'd0, cal_p9}, 16);
		w1 = sx64({32'd0, tfine}, 32) - 64'd128000;
		w2 = w1 * w1 * pk[6];
		w2 = w2 + ((w1 * pk[5]) << 17);
		w2 = w2 + (pk[4] << 35);
		w1 = sr64(w1 * w1 * pk[3], 8) + ((w1 * pk[2]) << 12);
		w1 = sr64(((64'd1 << 47) + w1) * pk[1], 33);
		press = '0;
		r.inval = (w1 == 0);
		if (!r.inval) begin
			p = 64'd1048576 - {44'd0, s.raw_p};
			p = ((p << 31) - w2) * 64'd3125;
			an = p[63] ? -p : p;
			ad = w1[63] ? -w1 : w1;
			q = an / ad;
			p = (p[63] != w1[63]) ? -q : q;
			ps = sr64(p, 13);
			w1 = sr64(pk[9] * ps * ps, 25);
			w2 = sr64(pk[8] * p, 19);
			press = sr64(p + w1 + w2, 8) + (pk[7] << 4);
		end
		r.press = press[31:0];
		h1 = {24'd0, cal_h[7:0]};
		h2 = sx32(cal_h >> 8, 16);
		h3 = {24'd0, cal_h[31:24]};
		h4 = sx32(cal_h >> 32, 12);
		h5 = sx32(cal_h >> 44, 12);
		h6 = sx32(cal_h >> 56, 8);
		v = tfine - 32'd76800;
		ha = sr32((({16'd0, s.raw_h} << 14) - (h4 << 20) - h5 * v) + 32'd16384, 15);
		hb = sr32(v * h6, 10);
		hc = sr32(v * h3, 11) + 32'd32768;
		hd = sr32(hb * hc, 10) + 32'd2097152;
		he = sr32(hd * h2 + 32'd8192, 14);
		hv = ha * he;
		hs = sr32(hv, 15);
		hv = hv - sr32(sr32(hs * hs, 7) * h1, 4);
		if (hv[31]) hv = 0;
		else if (hv > 32'd419430400) hv = 32'd419430400;
		r.hum = hv[28:12];
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_TEMP: cal_t = val[47:0];
			CFG_PRESS_LOW: cal_pl = val;
			CFG_PRESS_HIGH: cal_ph = val;
			CFG_PRESS_LAST: cal_p9 = val[15:0];
			CFG_HUM: cal_h = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || expected_readings.size() != 0 || in_valid)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Calibration close to a real sensor, so most samples reach the divider.
	task automatic set_typical();
		write_reg(CFG_TEMP, {16'(50 + $urandom_range(0, 20)),
			16'(26000 + $urandom_range(0, 2000)), 16'(27000 + $urandom_range(0, 2000))});
		write_reg(CFG_PRESS_LOW, {16'(2000 + $urandom_range(0, 9000)),
			16'(6000 + $urandom_range(0, 2000)),
			-16'(10000 + $urandom_range(0, 2000)), 16'(36000 + $urandom_range(0, 3000))});
		write_reg(CFG_PRESS_HIGH, {16'(4000 + $urandom_range(0, 1000)),
			-16'(14000 + $urandom_range(0, 2000)),
			16'($urandom_range(0, 15)), -16'($urandom_range(0, 100))});
		write_reg(CFG_PRESS_LAST, 16'(6000 + $urandom_range(0, 300)));
		write_reg(CFG_HUM, {8'd30, 12'(50), 12'(330), 8'd0, 16'(360), 8'd75});
	endtask

	task automatic add_samples(int n);
		sample_t s;
		for (int i = 0; i < n; i++) begin
			s.raw_t = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
				20'(400000 + $urandom_range(0, 200000));
			s.raw_p = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
				20'(250000 + $urandom_range(0, 200000));
			s.raw_h = 16'($urandom);
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; cal_h = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		// Reset calibration: the divisor is zero.
		pending_samples.push_back(sample_t'({20'hFFFFF, 20'h00000, 16'hFFFF}));
		pending_samples.push_back(sample_t'({20'h00000, 20'hFFFFF, 16'h0000}));
		wait_drained();
		set_typical();
		for (int i = 0; i < 8; i++) begin
			s.raw_t = (i & 1) ? 20'hFFFFF : 20'h00000;
			s.raw_p = (i & 2) ? 20'hFFFFF : 20'h00000;
			s.raw_h = (i & 4) ? 16'hFFFF : 16'h0000;
			pending_samples.push_back(s);
		end
		add_samples(8);
		wait_drained();
		// Extreme calibration values.
		write_reg(CFG_TEMP, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_PRESS_HIGH, 64'h8000_8000_8000_8000);
		write_reg(CFG_PRESS_LAST, 16'h8000);
		write_reg(CFG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
		add_samples(6);
		wait_drained();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 3 == 2) begin
				write_reg(CFG_TEMP, rnd64());
				write_reg(CFG_PRESS_LOW, rnd64());
				write_reg(CFG_PRESS_HIGH, rnd64());
				write_reg(CFG_PRESS_LAST, rnd64());
				write_reg(CFG_HUM, rnd64());
			end else begin
				set_typical();
			end
			add_samples(100);
			wait_drained();
		end
		stim_done = 1;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end else if (!hold_done && expected_readings.size() > 8) begin
				hold_done <= 1;
				hold_off <= 150;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_acc) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_samples.size() != 0) begin
				s_drive(pending_samples.pop_front());
				in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
			end else begin
				in_valid <= 1'b0;
			end
			if (hold_off > 0 || (!hold_done && expected_readings.size() > 8)) begin
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (out_acc && $urandom_range(0, 2) != 0) begin
				out_gap <= $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic s_drive(sample_t s);
		in_valid <= 1'b1;
		raw_temperature <= s.raw_t;
		raw_pressure <= s.raw_p;
		raw_humidity <= s.raw_h;
	endtask

	always @(posedge clk) begin
		reading_t e, g;
		in_acc <= arst_n && in_valid && !in_stall;
		out_acc <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall)
			expected_readings.push_back(compensate({raw_temperature, raw_pressure,
				raw_humidity}));
		if (arst_n && out_valid && !out_stall) begin
			g = {temperature, pressure, humidity, pressure_invalid};
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", g);
			end else begin
				e = expected_readings.pop_front();
				if (g !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected t=%h p=%h h=%h i=%b, got t=%h p=%h h=%h i=%b",
							e.temp, e.press, e.hum, e.inval, g.temp, g.press, g.hum, g.inval);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule
